// ===== hw/rtl/prr_pkg.sv =====
// Package for the link-ranking engine: sizes, codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package prr_pkg;

	localparam int MAX_PAGES = 1024;
	localparam int MAX_EDGES = 8192;
	localparam int PAGE_W    = 10;
	localparam int EDGE_AW   = $clog2(MAX_EDGES);
	localparam int ECNT_W    = EDGE_AW + 1;
	localparam int DEG_W     = ECNT_W;
	localparam int NPG_W     = 11;
	localparam int SCORE_W   = 32;
	localparam int DIV_W     = 48;
	localparam int EDGE_W    = 2 * PAGE_W;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_RUN   = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		CFG_PAGES = 2'd0,
		CFG_DAMP  = 2'd1,
		CFG_EPS   = 2'd2,
		CFG_MAXIT = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_CHECK, OP_CLR, OP_ADD_RD, OP_ADD_WR, OP_RD_ADDR,
		OP_RD_TAKE, OP_RESP, OP_START_DIV, OP_START_SET, OP_FILL, OP_BASE_DIV,
		OP_BASE_SET, OP_ACC_INIT, OP_E_RD, OP_E_SRC, OP_E_MUL, OP_E_SKIP,
		OP_E_DIV, OP_E_ACC, OP_U_RD, OP_U_SQ, OP_U_ADD, OP_CONV
	} op_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CHK, S_CLR, S_ADD_RD, S_ADD_WR, S_RD_ADDR, S_RD_TAKE,
		S_RESP, S_START, S_START_W, S_FILL, S_STEP, S_BASE_W, S_ACC_INIT,
		S_E0, S_E1, S_E2, S_E3, S_E4, S_UPD, S_U1, S_U2, S_CONV
	} state_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  stat_bad;
		logic  idx_last;
		logic  clr_last;
		logic  edge_end;
		logic  edge_skip;
		logic  div_done;
		logic  conv_hit;
		logic  iter_last;
		logic  out_free;
	} st_t;

endpackage

// ===== hw/rtl/prr_if.sv =====
// Handshake channel interfaces for request and response transactions.
// Depends on prr_pkg for field widths.
interface prr_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic [prr_pkg::PAGE_W-1:0] source_page;
	logic [prr_pkg::PAGE_W-1:0] target_page;
	modport source (output valid, kind, source_page, target_page, input ready);
	modport sink (input valid, kind, source_page, target_page, output ready);
endinterface

interface prr_out_if;
	logic                        valid;
	logic                        ready;
	logic [prr_pkg::SCORE_W-1:0] score;
	logic [15:0]                 iterations;
	logic                        converged;
	logic [1:0]                  status;
	modport source (output valid, score, iterations, converged, status, input ready);
	modport sink (input valid, score, iterations, converged, status, output ready);
endinterface

// ===== hw/rtl/prr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module prr_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/prr_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on prr_pkg for the operand widths.
module prr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [prr_pkg::DIV_W-1:0] dividend,
	input  logic [prr_pkg::DEG_W-1:0] divisor,
	output logic                      done,
	output logic [prr_pkg::DIV_W-1:0] quotient
);
	import prr_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEG_W-1:0] dsr_q, rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEG_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so its top bit drops out.
			rem_q <= fits ? DEG_W'(trial - {1'b0, dsr_q}) : trial[DEG_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held longer than a cycle");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
endmodule

// ===== hw/rtl/prr_ctrl.sv =====
// Controller state machine: sequences graph loads, score reads and the power
// iteration. Depends on prr_pkg for states, commands and status.
module prr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  prr_pkg::st_t   st,
	output prr_pkg::cmd_t  cmd
);
	import prr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.in_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.op = OP_CLR;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.op = OP_CHECK;
				unique case (st.kind)
					KIND_CLEAR: state_d = S_CLR;
					KIND_ADD:   state_d = S_ADD_RD;
					KIND_RUN:   state_d = S_START;
					KIND_READ:  state_d = S_RD_ADDR;
					default:    state_d = S_RESP;
				endcase
			end
			S_CLR: begin
				cmd.op = OP_CLR;
				if (st.clr_last) state_d = S_RESP;
			end
			S_ADD_RD: begin
				if (st.stat_bad) begin
					state_d = S_RESP;
				end else begin
					cmd.op  = OP_ADD_RD;
					state_d = S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				cmd.op  = OP_ADD_WR;
				state_d = S_RESP;
			end
			S_RD_ADDR: begin
				if (st.stat_bad) begin
					state_d = S_RESP;
				end else begin
					cmd.op  = OP_RD_ADDR;
					state_d = S_RD_TAKE;
				end
			end
			S_RD_TAKE: begin
				cmd.op  = OP_RD_TAKE;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.op  = OP_RESP;
					state_d = S_IDLE;
				end
			end
			S_START: begin
				cmd.op  = OP_START_DIV;
				state_d = S_START_W;
			end
			S_START_W: begin
				if (st.div_done) begin
					cmd.op  = OP_START_SET;
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.op = OP_FILL;
				if (st.idx_last) state_d = S_STEP;
			end
			S_STEP: begin
				cmd.op  = OP_BASE_DIV;
				state_d = S_BASE_W;
			end
			S_BASE_W: begin
				if (st.div_done) begin
					cmd.op  = OP_BASE_SET;
					state_d = S_ACC_INIT;
				end
			end
			S_ACC_INIT: begin
				cmd.op = OP_ACC_INIT;
				if (st.idx_last) state_d = S_E0;
			end
			S_E0: begin
				if (st.edge_end) begin
					state_d = S_UPD;
				end else begin
					cmd.op  = OP_E_RD;
					state_d = S_E1;
				end
			end
			S_E1: begin
				cmd.op  = OP_E_SRC;
				state_d = S_E2;
			end
			S_E2: begin
				if (st.edge_skip) begin
					cmd.op  = OP_E_SKIP;
					state_d = S_E0;
				end else begin
					cmd.op  = OP_E_MUL;
					state_d = S_E3;
				end
			end
			S_E3: begin
				cmd.op  = OP_E_DIV;
				state_d = S_E4;
			end
			S_E4: begin
				if (st.div_done) begin
					cmd.op  = OP_E_ACC;
					state_d = S_E0;
				end
			end
			S_UPD: begin
				cmd.op  = OP_U_RD;
				state_d = S_U1;
			end
			S_U1: begin
				cmd.op  = OP_U_SQ;
				state_d = S_U2;
			end
			S_U2: begin
				cmd.op  = OP_U_ADD;
				state_d = st.idx_last ? S_CONV : S_UPD;
			end
			S_CONV: begin
				cmd.op  = OP_CONV;
				state_d = (st.conv_hit || st.iter_last) ? S_RESP : S_STEP;
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_resp_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RESP |-> st.out_free) else $error("response without room");
	a_latch_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LATCH |=> state_q == S_CHK) else $error("latch not followed by check");
endmodule

// ===== hw/rtl/prr_dp.sv =====
// Datapath: configuration registers, link, degree and score memories, the
// shared divider, multipliers and the output register. Depends on prr_pkg,
// prr_if, prr_ram and prr_div.
module prr_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  prr_pkg::cmd_t             cmd,
	output prr_pkg::st_t              st,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic [1:0]                in_kind,
	input  logic [prr_pkg::PAGE_W-1:0] in_src,
	input  logic [prr_pkg::PAGE_W-1:0] in_dst,
	prr_out_if.source                 out_ch
);
	import prr_pkg::*;

	localparam logic [SCORE_W-1:0] SMAX = '1;

	logic [NPG_W-1:0]   pc_q;
	logic [15:0]        damp_q, maxit_q;
	logic [31:0]        eps_q;
	kind_t              kind_q;
	logic [PAGE_W-1:0]  src_q, dst_q, idx_q, edst_q;
	stat_t              stat_q;
	logic [SCORE_W-1:0] score_q, start_q, base_q;
	logic [ECNT_W-1:0]  ecount_q, eidx_q;
	logic [15:0]        iter_q;
	logic               conv_q, eskip_q;
	logic [63:0]        eps2_q, dist_q, sq_q;
	logic [DIV_W-1:0]   prod_q;
	logic [DEG_W-1:0]   deg_q;
	logic               out_valid_q;
	logic [SCORE_W-1:0] out_score_q;
	logic [15:0]        out_iter_q;
	logic               out_conv_q;
	logic [1:0]         out_stat_q;

	logic [NPG_W-1:0]   n;
	logic [PAGE_W-1:0]  n_last;
	logic [15:0]        cap;
	logic               idx_last;
	logic [EDGE_W-1:0]  edge_rd;
	logic [PAGE_W-1:0]  e_src, e_dst;
	logic [DEG_W-1:0]   deg_rd;
	logic [SCORE_W-1:0] old_rd, acc_rd;
	logic               edge_we, deg_we, old_we, acc_we;
	logic [PAGE_W-1:0]  deg_wa, deg_ra, old_wa, old_ra, acc_wa, acc_ra;
	logic [DEG_W-1:0]   deg_wd;
	logic [SCORE_W-1:0] old_wd, acc_wd;
	logic               div_start, div_done;
	logic [DIV_W-1:0]   div_num, quo;
	logic [DEG_W-1:0]   div_den;
	logic [SCORE_W-1:0] quo_sat, link_term, diff;
	logic [SCORE_W:0]   acc_sum;
	logic [64:0]        dist_sum;
	logic [32:0]        base_num;

	// Pages in use: zero counts as one, anything past the store as its size.
	always_comb begin
		if (pc_q == '0) n = NPG_W'(1);
		else if (pc_q > NPG_W'(MAX_PAGES)) n = NPG_W'(MAX_PAGES);
		else n = pc_q;
	end
	assign n_last   = PAGE_W'(n - 1'b1);
	assign idx_last = idx_q == n_last;
	assign cap      = (maxit_q == '0) ? 16'd1 : maxit_q;
	assign e_src    = edge_rd[EDGE_W-1:PAGE_W];
	assign e_dst    = edge_rd[PAGE_W-1:0];

	assign quo_sat   = (|quo[DIV_W-1:SCORE_W]) ? SMAX : quo[SCORE_W-1:0];
	assign link_term = quo[DIV_W-1:16];
	assign acc_sum   = {1'b0, acc_rd} + {1'b0, link_term};
	assign diff      = (old_rd > acc_rd) ? old_rd - acc_rd : acc_rd - old_rd;
	assign dist_sum  = {1'b0, dist_q} + {1'b0, sq_q};
	assign base_num  = (33'd65536 - {17'd0, damp_q}) << 16;

	// Memory ports.
	assign edge_we = cmd.op == OP_ADD_RD;
	assign deg_we  = cmd.op == OP_CLR || cmd.op == OP_ADD_WR;
	assign deg_wa  = (cmd.op == OP_CLR) ? idx_q : src_q;
	assign deg_wd  = (cmd.op == OP_CLR) ? '0 : DEG_W'(deg_rd + 1'b1);
	assign deg_ra  = (cmd.op == OP_E_SRC) ? e_src : src_q;
	assign old_we  = cmd.op == OP_FILL || cmd.op == OP_U_SQ;
	assign old_wa  = idx_q;
	assign old_wd  = (cmd.op == OP_FILL) ? start_q : acc_rd;
	assign old_ra  = (cmd.op == OP_E_SRC) ? e_src : (cmd.op == OP_RD_ADDR) ? dst_q : idx_q;
	assign acc_we  = cmd.op == OP_ACC_INIT || cmd.op == OP_E_ACC;
	assign acc_wa  = (cmd.op == OP_ACC_INIT) ? idx_q : edst_q;
	assign acc_wd  = (cmd.op == OP_ACC_INIT) ? base_q :
	                 (acc_sum[SCORE_W] ? SMAX : acc_sum[SCORE_W-1:0]);
	// The accumulator read address holds on the link target while the divider
	// runs, so its read data stays valid until the update.
	assign acc_ra  = (cmd.op == OP_U_RD) ? idx_q : edst_q;

	prr_ram #(.W(EDGE_W), .D(MAX_EDGES)) u_edge_ram (
		.clk, .we(edge_we), .waddr(ecount_q[EDGE_AW-1:0]), .wdata({src_q, dst_q}),
		.raddr(eidx_q[EDGE_AW-1:0]), .rdata(edge_rd));
	prr_ram #(.W(DEG_W), .D(MAX_PAGES)) u_deg_ram (
		.clk, .we(deg_we), .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd));
	prr_ram #(.W(SCORE_W), .D(MAX_PAGES)) u_old_ram (
		.clk, .we(old_we), .waddr(old_wa), .wdata(old_wd), .raddr(old_ra), .rdata(old_rd));
	prr_ram #(.W(SCORE_W), .D(MAX_PAGES)) u_acc_ram (
		.clk, .we(acc_we), .waddr(acc_wa), .wdata(acc_wd), .raddr(acc_ra), .rdata(acc_rd));

	always_comb begin
		div_start = 1'b1;
		div_num   = prod_q;
		div_den   = deg_q;
		case (cmd.op)
			OP_START_DIV: begin
				div_num = DIV_W'(64'h1_0000_0000);
				div_den = DEG_W'(n);
			end
			OP_BASE_DIV: begin
				div_num = DIV_W'(base_num);
				div_den = DEG_W'(n);
			end
			OP_E_DIV: ;
			default: div_start = 1'b0;
		endcase
	end

	prr_div u_div (
		.clk, .arst_n, .start(div_start), .dividend(div_num), .divisor(div_den),
		.done(div_done), .quotient(quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= NPG_W'(1);
			damp_q      <= 16'd55706;
			eps_q       <= 32'd21474836;
			maxit_q     <= 16'd1000;
			ecount_q    <= '0;
			idx_q       <= '0;
			iter_q      <= '0;
			conv_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_PAGES: pc_q    <= cfg_data[NPG_W-1:0];
					CFG_DAMP:  damp_q  <= cfg_data[15:0];
					CFG_EPS:   eps_q   <= cfg_data;
					CFG_MAXIT: maxit_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_RESP) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_CLR: begin
					idx_q    <= PAGE_W'(idx_q + 1'b1);
					ecount_q <= '0;
				end
				OP_ADD_WR: ecount_q <= ecount_q + 1'b1;
				OP_START_SET: begin
					idx_q  <= '0;
					iter_q <= '0;
				end
				OP_BASE_SET: idx_q <= '0;
				OP_FILL, OP_ACC_INIT, OP_U_ADD: idx_q <= idx_last ? '0 : idx_q + 1'b1;
				OP_CONV: begin
					iter_q <= iter_q + 1'b1;
					conv_q <= dist_q < eps2_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				kind_q <= kind_t'(in_kind);
				src_q  <= in_src;
				dst_q  <= in_dst;
			end
			OP_CHECK: begin
				score_q <= '0;
				stat_q  <= STAT_OK;
				if (kind_q == KIND_ADD) begin
					if ({1'b0, src_q} >= n || {1'b0, dst_q} >= n) stat_q <= STAT_RANGE;
					else if (ecount_q == ECNT_W'(MAX_EDGES)) stat_q <= STAT_FULL;
				end else if (kind_q == KIND_READ && {1'b0, dst_q} >= n) begin
					stat_q <= STAT_RANGE;
				end
			end
			OP_RD_TAKE: score_q <= old_rd;
			OP_RESP: begin
				out_score_q <= score_q;
				out_iter_q  <= iter_q;
				out_conv_q  <= conv_q;
				out_stat_q  <= stat_q;
			end
			OP_START_SET: begin
				start_q <= quo_sat;
				eps2_q  <= eps_q * eps_q;
			end
			OP_BASE_SET: begin
				base_q <= quo_sat;
				eidx_q <= '0;
				dist_q <= '0;
			end
			OP_E_SRC: begin
				edst_q  <= e_dst;
				eskip_q <= {1'b0, e_src} >= n || {1'b0, e_dst} >= n;
			end
			OP_E_MUL: begin
				prod_q <= DIV_W'(damp_q * old_rd);
				deg_q  <= deg_rd;
			end
			OP_E_SKIP, OP_E_ACC: eidx_q <= eidx_q + 1'b1;
			OP_U_SQ: sq_q <= diff * diff;
			OP_U_ADD: dist_q <= dist_sum[64] ? '1 : dist_sum[63:0];
			default: ;
		endcase
	end

	assign st.kind      = kind_q;
	assign st.stat_bad  = stat_q != STAT_OK;
	assign st.idx_last  = idx_last;
	assign st.clr_last  = idx_q == PAGE_W'(MAX_PAGES - 1);
	assign st.edge_end  = eidx_q == ecount_q;
	assign st.edge_skip = eskip_q || deg_rd == '0;
	assign st.div_done  = div_done;
	assign st.conv_hit  = dist_q < eps2_q;
	assign st.iter_last = ({1'b0, iter_q} + 17'd1) >= {1'b0, cap};
	assign st.out_free  = !out_valid_q || out_ch.ready;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.score      = out_score_q;
	assign out_ch.iterations = out_iter_q;
	assign out_ch.converged  = out_conv_q;
	assign out_ch.status     = out_stat_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ecount_q <= ECNT_W'(MAX_EDGES)) else $error("link count past store size");
	a_acc_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_E_ACC |-> div_done) else $error("accumulate without quotient");
	a_edge_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_E_RD |-> eidx_q < ecount_q) else $error("link walk past count");
endmodule

// ===== hw/rtl/pagerank_power_iteration.sv =====
// Top level of the link-ranking engine: controller plus datapath.
// Depends on prr_pkg, prr_if, prr_ctrl and prr_dp.
//
//  channel  dir   handshake      contents
//  in_ch    in    valid/ready    kind, source_page, target_page
//  out_ch   out   valid/ready    score, iterations, converged, status
//  cfg      in    cfg_we         cfg_index, cfg_data (write only)
//
// A run divides once for the start score; each iteration then divides once for
// the base score and once per stored link not skipped, on the bit-serial divider.
// After reset a clearing pass over the degree memory runs first.
// A finished result waits in the output register while the next item is taken.
module pagerank_power_iteration (
	input  logic        clk,
	input  logic        arst_n,
	prr_in_if.sink      in_ch,
	prr_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import prr_pkg::*;

	cmd_t cmd;
	st_t  st;

	assign in_ch.ready = cmd.in_ready;

	prr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(in_ch.valid), .st, .cmd);

	prr_dp u_dp (
		.clk, .arst_n, .cmd, .st, .cfg_we, .cfg_index, .cfg_data,
		.in_kind(in_ch.kind), .in_src(in_ch.source_page), .in_dst(in_ch.target_page),
		.out_ch);
endmodule
